/* hdl/tns_pkg.sv */
package tns_pkg;

	localparam int SCORE_W        = 8;
	localparam int CLASS_W        = 10;
	localparam int RANK_W         = 4;
	localparam int CFG_W          = 5;
	localparam int SEL_RESET      = 5;
	localparam int SEL_MAX        = 16;
	localparam int MAX_SCORES_DEF = 1024;
	localparam int MAX_PICKS_DEF  = 16;

	// Saturate a written pick count to 1..SEL_MAX.
	function automatic logic [CFG_W-1:0] clamp_select(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > CFG_W'(SEL_MAX)) begin
			r = CFG_W'(SEL_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* hdl/top_n_score_selector.sv */
// Top-N score selector. Scores of one vector arrive one word per cycle on the
// input channel (ready stays high while loading), in index order, and are
// written into a single-port-per-side score RAM; vector_end marks the last
// word. Scores that arrive when MAX_SCORES are already held are dropped and
// reported through overflow_seen on every result of that vector. After the
// marked word the block passes through a setup state, then runs one scan pass
// over the stored scores per result: a pass reads the RAM one entry per cycle
// through one shared compare unit, and a vector of L scores yields
// P = min(select_count, MAX_PICKS, L) results. Each pass picks the best score
// that ranks below the previous pick (higher score first, lower index first
// on a tie), so no per-entry taken marks are kept. Results come out best
// first; run_end marks the last one. The input is not ready during
// selection. select_count may be written only while the block is idle;
// written values saturate to 1..16, reset value 5.
module top_n_score_selector
	import tns_pkg::*;
#(
	parameter int MAX_SCORES = MAX_SCORES_DEF,
	parameter int MAX_PICKS  = MAX_PICKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [SCORE_W-1:0] score_value,
	input  logic               vector_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RANK_W-1:0]  rank_position,
	output logic [CLASS_W-1:0] class_index,
	output logic [SCORE_W-1:0] chosen_score,
	output logic               run_end,
	output logic               overflow_seen
);

	localparam int IDX_W  = (MAX_SCORES > 1) ? $clog2(MAX_SCORES) : 1;
	localparam int CNT_W  = $clog2(MAX_SCORES + 1);
	localparam int PK_W   = $clog2(MAX_PICKS + 1);
	localparam int CMP_A  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int CMP_W  = (CMP_A > PK_W) ? CMP_A : PK_W;

	localparam logic [1:0] S_LOAD  = 2'd0;
	localparam logic [1:0] S_SETUP = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0]         state_q;
	logic [CFG_W-1:0]   sel_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic [PK_W-1:0]    picks_q;
	logic [PK_W-1:0]    rank_q;

	// scan bookkeeping
	logic [IDX_W-1:0]   addr_q;
	logic               issue_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [SCORE_W-1:0] rd_data_s1;

	logic               prev_vld_q;
	logic [SCORE_W-1:0] prev_score_q;
	logic [IDX_W-1:0]   prev_idx_q;
	logic               have_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [IDX_W-1:0]   best_idx_q;

	// output register
	logic               out_vld_q;
	logic [PK_W-1:0]    out_rank_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [SCORE_W-1:0] out_score_q;
	logic               out_end_q;
	logic               out_ovf_q;

	logic               in_acc;
	logic               out_acc;
	logic               room;
	logic               wr_en;
	logic               rd_en;
	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   last_addr;
	logic               eligible;
	logic               better;
	logic               have_nxt;
	logic [SCORE_W-1:0] best_score_nxt;
	logic [IDX_W-1:0]   best_idx_nxt;
	logic               pass_done;
	logic [CMP_W-1:0]   sel_ext;
	logic [CMP_W-1:0]   lim_ext;
	logic [CMP_W-1:0]   cnt_ext;
	logic [CMP_W-1:0]   picks_c;
	logic [PK_W-1:0]    rank_inc;
	logic [IDX_W+CLASS_W-1:0] idx_wide;
	logic [PK_W+RANK_W-1:0]   rank_wide;

	assign in_ready = (state_q == S_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_vld_q && out_ready;
	assign room     = (cnt_q < CNT_W'(MAX_SCORES));
	assign wr_en    = in_acc && room;
	assign rd_en    = (state_q == S_SCAN) && issue_q;
	assign cnt_m1   = cnt_q - 1'b1;
	assign last_addr = cnt_m1[IDX_W-1:0];

	tns_ram #(
		.WIDTH(SCORE_W),
		.DEPTH(MAX_SCORES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(cnt_q[IDX_W-1:0]),
		.wr_data(score_value),
		.rd_en  (rd_en),
		.rd_addr(addr_q),
		.rd_data(rd_data_s1)
	);

	// Shared compare: entry must rank below the previous pick, then beat the
	// running best. Strict greater keeps the lower index on a tie.
	always_comb begin
		eligible = !prev_vld_q || (rd_data_s1 < prev_score_q) ||
			((rd_data_s1 == prev_score_q) && (rd_idx_s1 > prev_idx_q));
		better = rd_vld_s1 && eligible && (!have_q || (rd_data_s1 > best_score_q));
		have_nxt       = have_q || better;
		best_score_nxt = better ? rd_data_s1 : best_score_q;
		best_idx_nxt   = better ? rd_idx_s1 : best_idx_q;
	end

	assign pass_done = (state_q == S_SCAN) && !issue_q && rd_vld_s1;

	// Result count: min(select_count, MAX_PICKS, loaded_count).
	always_comb begin
		sel_ext = CMP_W'(sel_q);
		lim_ext = (sel_ext < CMP_W'(MAX_PICKS)) ? sel_ext : CMP_W'(MAX_PICKS);
		cnt_ext = CMP_W'(cnt_q);
		picks_c = (cnt_ext < lim_ext) ? cnt_ext : lim_ext;
	end

	assign rank_inc = rank_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			sel_q      <= CFG_W'(SEL_RESET);
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			issue_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			prev_vld_q <= 1'b0;
			have_q     <= 1'b0;
			out_vld_q  <= 1'b0;
			rank_q     <= '0;
			picks_q    <= '0;
		end else begin
			if (cfg_we) begin
				sel_q <= clamp_select(cfg_wdata);
			end
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (vector_end) begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					picks_q    <= picks_c[PK_W-1:0];
					rank_q     <= '0;
					prev_vld_q <= 1'b0;
					have_q     <= 1'b0;
					addr_q     <= '0;
					issue_q    <= 1'b1;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					// issue one read per cycle until the last stored entry
					rd_vld_s1 <= issue_q;
					rd_idx_s1 <= addr_q;
					if (issue_q) begin
						if (addr_q == last_addr) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					have_q       <= have_nxt;
					best_score_q <= best_score_nxt;
					best_idx_q   <= best_idx_nxt;
					if (pass_done) begin
						rd_vld_s1   <= 1'b0;
						out_vld_q   <= 1'b1;
						out_rank_q  <= rank_q;
						out_idx_q   <= best_idx_nxt;
						out_score_q <= best_score_nxt;
						out_end_q   <= (rank_inc == picks_q);
						out_ovf_q   <= ovf_q;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_acc) begin
						out_vld_q <= 1'b0;
						if (out_end_q) begin
							// drop the vector and go back to loading
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							// next pass ranks below the word just sent
							rank_q       <= rank_inc;
							prev_vld_q   <= 1'b1;
							prev_score_q <= out_score_q;
							prev_idx_q   <= out_idx_q;
							have_q       <= 1'b0;
							addr_q       <= '0;
							issue_q      <= 1'b1;
							state_q      <= S_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign idx_wide  = {{CLASS_W{1'b0}}, out_idx_q};
	assign rank_wide = {{RANK_W{1'b0}}, out_rank_q};

	assign out_valid     = out_vld_q;
	assign rank_position = rank_wide[RANK_W-1:0];
	assign class_index   = idx_wide[CLASS_W-1:0];
	assign chosen_score  = out_score_q;
	assign run_end       = out_end_q;
	assign overflow_seen = out_ovf_q;

endmodule

/* hdl/tns_ram.sv */
module tns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
